@@ rtl/swr_pkg.sv @@
// ----------------------------------------------------------------------------
// Stack with reverse: shared package
// Sizes, command and status codes, and the transaction payload types.
// ----------------------------------------------------------------------------
package swr_pkg;

   // Stack geometry.
   localparam int STACK_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int WORD_W      = 32;
   localparam int OUT_CNT_W   = 9;

   // Command codes.
   localparam logic [1:0] OP_PUSH    = 2'd0;
   localparam logic [1:0] OP_POP     = 2'd1;
   localparam logic [1:0] OP_PEEK    = 2'd2;
   localparam logic [1:0] OP_REVERSE = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Request transaction payload.
   typedef struct packed {
      logic [1:0]        opcode;
      logic [WORD_W-1:0] push_value;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic [WORD_W-1:0]    read_value;
      logic [1:0]           status;
      logic [OUT_CNT_W-1:0] entry_count;
   } rsp_type;

   // Access request from the sequencer to the stack memory.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [WORD_W-1:0] wdata;
      logic              rd_en;
      logic [ADDR_W-1:0] raddr_a;
      logic [ADDR_W-1:0] raddr_b;
   } mem_req_type;

endpackage

@@ rtl/swr_mem.sv @@
// ----------------------------------------------------------------------------
// Stack memory
// One write port and two registered read ports; read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
module swr_mem
   import swr_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [WORD_W-1:0] rdata_a,
   output logic [WORD_W-1:0] rdata_b
);

   logic [WORD_W-1:0] store_ff [STACK_DEPTH];
   logic [WORD_W-1:0] rdata_a_ff;
   logic [WORD_W-1:0] rdata_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Two read ports with registered data.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rdata_a_ff <= store_ff[mem_req.raddr_a];
         rdata_b_ff <= store_ff[mem_req.raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

@@ rtl/swr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Stack sequencer
// Holds the entry count, decodes commands and steps the in-place reverse
// through the memory one pair of entries at a time: read both, write low, write high.
// ----------------------------------------------------------------------------
module swr_ctrl
   import swr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  req_type           req_data,
   output logic              req_stall,
   output logic              res_valid,
   output rsp_type           res_data,
   input  logic              res_take,
   output mem_req_type       mem_req,
   input  logic [WORD_W-1:0] rdata_a,
   input  logic [WORD_W-1:0] rdata_b
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SW_RD,
      S_SW_WLO,
      S_SW_WHI,
      S_TOP_RD,
      S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] lo_ff, lo_in;
   logic [ADDR_W-1:0] hi_ff, hi_in;
   logic [1:0]        status_ff, status_in;
   logic              use_mem_ff, use_mem_in;

   logic [CNT_W-1:0]  count_m1;
   logic [ADDR_W-1:0] top_addr;
   logic [ADDR_W-1:0] lo_next;
   logic [ADDR_W-1:0] hi_next;

   // Address of the current top entry, and the next swap pair.
   assign count_m1 = count_ff - CNT_W'(1);
   assign top_addr = count_m1[ADDR_W-1:0];
   assign lo_next  = lo_ff + ADDR_W'(1);
   assign hi_next  = hi_ff - ADDR_W'(1);

   // Next-state and memory access decode.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      status_in  = status_ff;
      use_mem_in = use_mem_ff;
      mem_req    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               use_mem_in = 1'b0;
               status_in  = ST_OK;
               state_in   = S_EMIT;
               unique case (req_data.opcode)
                  OP_PUSH: begin
                     if (count_ff == CNT_W'(STACK_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = count_ff[ADDR_W-1:0];
                        mem_req.wdata = req_data.push_value;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.raddr_a = top_addr;
                        use_mem_in      = 1'b1;
                        count_in        = count_m1;
                     end
                  end
                  OP_PEEK: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.raddr_a = top_addr;
                        use_mem_in      = 1'b1;
                     end
                  end
                  default: begin
                     // Reverse: swap pairs from both ends when two or more
                     // entries are held; a single entry just reads back.
                     if (count_ff > CNT_W'(1)) begin
                        lo_in    = '0;
                        hi_in    = top_addr;
                        state_in = S_SW_RD;
                     end else if (count_ff == CNT_W'(1)) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.raddr_a = '0;
                        use_mem_in      = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_SW_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.raddr_a = lo_ff;
            mem_req.raddr_b = hi_ff;
            state_in        = S_SW_WLO;
         end
         S_SW_WLO: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = lo_ff;
            mem_req.wdata = rdata_b;
            state_in      = S_SW_WHI;
         end
         S_SW_WHI: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = hi_ff;
            mem_req.wdata = rdata_a;
            lo_in         = lo_next;
            hi_in         = hi_next;
            if (lo_next < hi_next) begin
               state_in = S_SW_RD;
            end else begin
               state_in = S_TOP_RD;
            end
         end
         S_TOP_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.raddr_a = top_addr;
            use_mem_in      = 1'b1;
            state_in        = S_EMIT;
         end
         S_EMIT: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         lo_ff      <= '0;
         hi_ff      <= '0;
         status_ff  <= ST_OK;
         use_mem_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         status_ff  <= status_in;
         use_mem_ff <= use_mem_in;
      end
   end

   // Result offered to the output register.
   assign req_stall            = (state_ff != S_IDLE);
   assign res_valid            = (state_ff == S_EMIT);
   assign res_data.read_value  = use_mem_ff ? rdata_a : '0;
   assign res_data.status      = status_ff;
   assign res_data.entry_count = OUT_CNT_W'(count_ff);

endmodule

@@ rtl/stack_with_reverse_unit.sv @@
// ----------------------------------------------------------------------------
// Stack with reverse: top level
// A LIFO stack of 32-bit words with push, pop, peek and in-place reverse.
//
// The request channel (req_valid, req_stall, req_data) carries one command
// per transaction; every request yields exactly one response transaction on
// rsp_valid, rsp_stall, rsp_data with the read word, status and entry count.
// A refused push (stack full) or pop/peek (stack empty) changes nothing.
// Push, pop, peek and a reverse of fewer than two entries make at most one
// memory access when accepted; the result goes to the output register and
// then raises rsp_valid. A reverse of two or more entries first swaps
// floor(n / 2) pairs of its n entries and then reads the new top before
// the result is offered; each pair swap is one dual read and two writes
// through one write port.
// A new request is taken once the sequencer is idle again, even while the
// previous response still waits in the output register. While the receiver
// stalls, the response holds and the sequencer waits to hand over the next.
// Synchronous reset empties the stack and clears the response valid flag;
// stored words are not cleared, as only held entries are ever read.
// ----------------------------------------------------------------------------
module stack_with_reverse_unit
   import swr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   mem_req_type       mem_req;
   logic [WORD_W-1:0] rdata_a;
   logic [WORD_W-1:0] rdata_b;
   logic              res_valid;
   rsp_type           res_data;
   logic              res_take;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   swr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_take  (res_take),
      .mem_req   (mem_req),
      .rdata_a   (rdata_a),
      .rdata_b   (rdata_b)
   );

   swr_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   // The output register takes a new result once it is empty or draining.
   assign res_take = !rsp_valid_ff || !rsp_stall;

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take && res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the stack with reverse
// Drives push, pop, peek and reverse commands into stack_with_reverse_unit.
// It starts with a short directed table and then runs randomized phases that
// fill, drain and mix traffic. A shadow copy of the stack predicts every
// response, and each response is compared field by field in arrival order.
// Both sides insert random idle cycles, and the receiver holds off for a
// long stretch once so that the block backs up.
// ----------------------------------------------------------------------------
module tb_top;
   import swr_pkg::*;

   localparam int          RANDOM_ITEMS  = 1300;
   localparam int unsigned CYCLE_LIMIT   = 2_000_000;
   localparam int          HOLD_CYCLES   = 60;
   localparam int          SETTLE_CYCLES = 20;
   localparam int          MAX_REPORTS   = 30;

   // Kinds of random phase.
   localparam int unsigned PHASE_FILL  = 0;
   localparam int unsigned PHASE_DRAIN = 1;
   localparam int unsigned PHASE_PUSHY = 2;
   localparam int unsigned PHASE_POPPY = 3;

   // One row of the directed table. When typed is set, want is the response
   // to check against; otherwise the shadow stack supplies it.
   typedef struct packed {
      req_type cmd;
      logic    typed;
      rsp_type want;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 22;
   localparam directed_row_type DIRECTED_TABLE [0:DIRECTED_ROWS-1] = '{
      {OP_PEEK,    32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY, 9'd0},
      {OP_POP,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY, 9'd0},
      {OP_REVERSE, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,    9'd0},
      {OP_PUSH,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK,    9'd1},
      {OP_REVERSE, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK,    9'd1},
      {OP_PEEK,    32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK,    9'd1},
      {OP_PUSH,    32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,    9'd2},
      {OP_PUSH,    32'h3F80_0000, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_PUSH,    32'h7FC0_0000, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_PUSH,    32'h8000_0000, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_REVERSE, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_POP,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_REVERSE, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_PEEK,    32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_POP,     32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_PEEK,    32'h5A5A_5A5A, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_REVERSE, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_POP,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_POP,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_POP,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK,    9'd0},
      {OP_POP,     32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY, 9'd0},
      {OP_PEEK,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY, 9'd0}
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Shadow copy of the stack; entry 0 is the bottom.
   logic [WORD_W-1:0] stack_image [STACK_DEPTH];
   int unsigned       image_count = 0;

   rsp_type     awaited_responses [$];
   int unsigned mismatch_count    = 0;
   int unsigned checked_count     = 0;
   int unsigned accepted_commands = 0;
   int unsigned cycle_count       = 0;
   int unsigned op_counts [4]     = '{0, 0, 0, 0};
   int unsigned refused_full      = 0;
   int unsigned refused_empty     = 0;
   int unsigned deepest_stack     = 0;
   bit          steady_flow       = 1'b0;
   bit          hold_off_pending  = 1'b0;

   stack_with_reverse_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Free-running clock, period 8.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still awaited",
                  cycle_count, awaited_responses.size());
         $display("** stack_with_reverse_unit: FAILED **");
         $finish;
      end
   end

   // Applies one command to the shadow stack and returns its response.
   function automatic rsp_type apply_stack_command(input req_type cmd);
      rsp_type           outcome;
      logic [WORD_W-1:0] swap_word;
      int unsigned       lo_idx;
      int unsigned       hi_idx;
      outcome = '0;
      outcome.status = ST_OK;
      case (cmd.opcode)
         OP_PUSH: begin
            if (image_count >= STACK_DEPTH) begin
               outcome.status = ST_FULL;
               refused_full++;
            end else begin
               stack_image[image_count] = cmd.push_value;
               image_count++;
            end
         end
         OP_POP: begin
            if (image_count == 0) begin
               outcome.status = ST_EMPTY;
               refused_empty++;
            end else begin
               image_count--;
               outcome.read_value = stack_image[image_count];
            end
         end
         OP_PEEK: begin
            if (image_count == 0) begin
               outcome.status = ST_EMPTY;
               refused_empty++;
            end else begin
               outcome.read_value = stack_image[image_count-1];
            end
         end
         OP_REVERSE: begin
            // Swap mirrored entries toward the middle.
            if (image_count > 1) begin
               lo_idx = 0;
               hi_idx = image_count - 1;
               while (lo_idx < hi_idx) begin
                  swap_word           = stack_image[lo_idx];
                  stack_image[lo_idx] = stack_image[hi_idx];
                  stack_image[hi_idx] = swap_word;
                  lo_idx++;
                  hi_idx--;
               end
            end
            if (image_count != 0) outcome.read_value = stack_image[image_count-1];
         end
         default: ;
      endcase
      outcome.entry_count = OUT_CNT_W'(image_count);
      op_counts[cmd.opcode]++;
      if (image_count > deepest_stack) deepest_stack = image_count;
      return outcome;
   endfunction

   // Draws a command with the given push, pop and peek percentages;
   // the rest of the range is reverse.
   function automatic req_type random_command(input int unsigned push_pct,
                                              input int unsigned pop_pct,
                                              input int unsigned peek_pct);
      req_type     cmd;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      cmd.push_value = $urandom();
      if (roll < push_pct) cmd.opcode = OP_PUSH;
      else if (roll < push_pct + pop_pct) cmd.opcode = OP_POP;
      else if (roll < push_pct + pop_pct + peek_pct) cmd.opcode = OP_PEEK;
      else cmd.opcode = OP_REVERSE;
      return cmd;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   // Offers one command after a random gap and records its expected
   // response once the block accepts it.
   task automatic send_command(input req_type cmd, input logic typed,
                               input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         req_data  <= {2'($urandom_range(0, 3)), $urandom()};
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = apply_stack_command(cmd);
      awaited_responses.push_back(typed ? want : predicted);
      accepted_commands++;
   endtask

   task automatic send_random(input int unsigned push_pct, input int unsigned pop_pct,
                              input int unsigned peek_pct);
      send_command(random_command(push_pct, pop_pct, peek_pct), 1'b0, '0);
   endtask

   // Compares an accepted response with the oldest expectation.
   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (awaited_responses.size() == 0) begin
         report_mismatch($sformatf("unexpected response %h", got));
         return;
      end
      want = awaited_responses.pop_front();
      checked_count++;
      if (got.read_value !== want.read_value)
         report_mismatch($sformatf("read_value %h, want %h", got.read_value,
                                   want.read_value));
      if (got.status !== want.status)
         report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.entry_count !== want.entry_count)
         report_mismatch($sformatf("entry_count %0d, want %0d", got.entry_count,
                                   want.entry_count));
   endtask

   // Response monitor.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         check_response(rsp_data);
   end

   // Receiver: a random stall after each accepted response, plus one long
   // hold-off when the stimulus asks for it.
   initial begin : receiver
      int gap;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (reset !== 1'b0) begin
            // Nothing to do until reset is released.
         end else if (hold_off_pending) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off_pending = 1'b0;
         end else if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            gap = steady_flow ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Main stimulus: reset, directed table, random phases, then wind-down.
   initial begin : stimulus
      int          row;
      int unsigned phase_idx;
      int unsigned phase_kind;
      int unsigned phase_len;
      int unsigned extra;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      for (row = 0; row < DIRECTED_ROWS; row++)
         send_command(DIRECTED_TABLE[row].cmd, DIRECTED_TABLE[row].typed,
                      DIRECTED_TABLE[row].want);

      // The receiver holds off while the first fill keeps offering pushes.
      hold_off_pending = 1'b1;
      phase_idx = 0;
      while (accepted_commands < DIRECTED_ROWS + RANDOM_ITEMS) begin
         phase_kind  = (phase_idx < 2) ? phase_idx : $urandom_range(0, 7);
         steady_flow = ($urandom_range(0, 3) == 0);
         phase_len   = $urandom_range(20, 80);
         extra       = $urandom_range(1, 3);
         case (phase_kind)
            PHASE_FILL: begin
               // Fill to the top, try pushes that must be refused, then
               // reverse the full stack and look at the new top.
               while (image_count < STACK_DEPTH) send_random(100, 0, 0);
               repeat (extra) send_random(100, 0, 0);
               send_random(0, 0, 0);
               send_random(0, 0, 100);
            end
            PHASE_DRAIN: begin
               while (image_count != 0) send_random(0, 100, 0);
               repeat (extra) send_random(0, 50, 50);
               send_random(0, 0, 0);
            end
            PHASE_PUSHY: repeat (phase_len) send_random(60, 15, 10);
            PHASE_POPPY: repeat (phase_len) send_random(15, 60, 10);
            default:     repeat (phase_len) send_random(35, 30, 15);
         endcase
         phase_idx++;
      end
      req_valid <= 1'b0;
      steady_flow = 1'b0;

      // Let every response come back, then watch for strays.
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d commands (%0d push, %0d pop, %0d peek, %0d reverse), %0d checked.",
               accepted_commands, op_counts[OP_PUSH], op_counts[OP_POP],
               op_counts[OP_PEEK], op_counts[OP_REVERSE], checked_count);
      $display("Refused %0d pushes when full, %0d pops or peeks when empty; deepest %0d of %0d.",
               refused_full, refused_empty, deepest_stack, STACK_DEPTH);
      if (mismatch_count == 0) begin
         $display("** stack_with_reverse_unit: PASSED **");
      end else begin
         $display("** stack_with_reverse_unit: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/swr_pkg.sv
rtl/swr_mem.sv
rtl/swr_ctrl.sv
rtl/stack_with_reverse_unit.sv
tb/tb_top.sv
